// File: rtl/tse_pkg.sv
`timescale 1ns / 1ps

package tse_pkg;

	// Default sizes for the top-level parameters.
	localparam int DEF_MAX_STOPS = 8;
	localparam int DEF_TAB_WIDTH = 8;

	// Field and register widths.
	localparam int CHAR_W      = 8;
	localparam int COLUMN_W    = 8;
	localparam int COUNT_W     = 8;
	localparam int STOP_W      = 8;
	localparam int USED_W      = 4;
	localparam int CFG_DATA_W  = 64;
	localparam int CFG_INDEX_W = 1;

	// Character codes of interest.
	localparam logic [CHAR_W-1:0] CHAR_TAB     = 8'd9;
	localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;
	localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'd32;

	// Highest column that the tracker will report.
	localparam logic [COLUMN_W-1:0] COLUMN_MAX = 8'd255;

	// Configuration register indexes.
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_STOP_COLUMNS = 1'b0,
		REG_STOPS_IN_USE = 1'b1
	} cfg_reg_t;

endpackage

// File: rtl/tse_cfg_regs.sv
`timescale 1ns / 1ps

module tse_cfg_regs #(
	parameter int MAX_STOPS = tse_pkg::DEF_MAX_STOPS
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          cfg_write,
	input  logic [tse_pkg::CFG_INDEX_W-1:0]               cfg_index,
	input  logic [tse_pkg::CFG_DATA_W-1:0]                cfg_data,
	output logic [MAX_STOPS-1:0][tse_pkg::STOP_W-1:0]     stops,
	output logic [tse_pkg::USED_W-1:0]                    stops_used
);
	import tse_pkg::*;

	logic [MAX_STOPS-1:0][STOP_W-1:0] stops_q;
	logic [USED_W-1:0]                used_q;

	// Register file: only the stops that the block can use are kept.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stops_q <= '0;
			used_q  <= '0;
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_STOP_COLUMNS: begin
					for (int k = 0; k < MAX_STOPS; k++) begin
						stops_q[k] <= cfg_data[STOP_W*k +: STOP_W];
					end
				end
				REG_STOPS_IN_USE: begin
					used_q <= cfg_data[USED_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign stops      = stops_q;
	assign stops_used = used_q;

endmodule

// File: rtl/tse_tab_dist.sv
`timescale 1ns / 1ps

module tse_tab_dist #(
	parameter int MAX_STOPS = tse_pkg::DEF_MAX_STOPS,
	parameter int TAB_WIDTH = tse_pkg::DEF_TAB_WIDTH
) (
	input  logic [tse_pkg::COLUMN_W-1:0]                  column,
	input  logic [MAX_STOPS-1:0][tse_pkg::STOP_W-1:0]     stops,
	input  logic [tse_pkg::USED_W-1:0]                    stops_used,
	output logic [tse_pkg::COUNT_W-1:0]                   distance
);
	import tse_pkg::*;

	// Reciprocal of the tab width, scaled by 2^16, rounded up. With an
	// 8-bit column and a width of at most 64 the quotient is exact.
	localparam int RECIP_SHIFT = 16;
	localparam int RECIP_W     = RECIP_SHIFT + 1;
	localparam int PROD_W      = RECIP_W + COLUMN_W;
	localparam int QUOT_W      = PROD_W - RECIP_SHIFT;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((1 << RECIP_SHIFT) + TAB_WIDTH - 1) / TAB_WIDTH);
	localparam logic [COUNT_W-1:0] TAB_WIDTH_C = COUNT_W'(TAB_WIDTH);
	localparam logic [USED_W-1:0]  MAX_USED    = USED_W'(MAX_STOPS);

	logic [USED_W-1:0]  used_clamped;
	logic [PROD_W-1:0]  product;
	logic [QUOT_W-1:0]  quotient;
	logic [PROD_W-1:0]  multiple;
	logic [COLUMN_W-1:0] remainder;
	logic [COUNT_W-1:0] fixed_dist;
	logic               stop_hit;
	logic [COUNT_W-1:0] stop_dist;

	// A stop count beyond the number held is treated as all of them.
	assign used_clamped = (stops_used > MAX_USED) ? MAX_USED : stops_used;

	// Distance to the next multiple of the tab width.
	assign product    = PROD_W'(column) * PROD_W'(RECIP);
	assign quotient   = product[PROD_W-1:RECIP_SHIFT];
	assign multiple   = PROD_W'(quotient) * PROD_W'(TAB_WIDTH);
	assign remainder  = column - multiple[COLUMN_W-1:0];
	assign fixed_dist = TAB_WIDTH_C - COUNT_W'(remainder);

	// First valid stop in index order lying beyond the column. The scan runs
	// downwards so that the lowest matching index is the one kept.
	always_comb begin
		stop_hit  = 1'b0;
		stop_dist = '0;
		for (int k = MAX_STOPS - 1; k >= 0; k--) begin
			if ((USED_W'(k) < used_clamped) && (stops[k] > column)) begin
				stop_hit  = 1'b1;
				stop_dist = COUNT_W'(stops[k] - column);
			end
		end
	end

	assign distance = stop_hit ? stop_dist : fixed_dist;

endmodule

// File: rtl/tab_stop_expander_unit.sv
`timescale 1ns / 1ps

// Tab stop expander: one byte goes in per request and one result comes out.
// Input channel: in_valid, in_stall and in_char. Output channel: out_valid,
// out_stall, out_char, repeat_count and column_after. A tab leaves as a
// space with the number of copies needed to reach the next tab stop; any
// other byte leaves unchanged with a count of one, and a newline returns
// the column to zero.
// Tab stops are loaded through cfg_write, cfg_index and cfg_data: index 0
// takes the packed stop columns, index 1 the number of stops in use. Write
// them only while no request is in flight.
// A request that is taken sits in the input register; from there the column
// update loads the result register and raises out_valid once the result
// register is free or being emptied. One request is accepted every cycle
// while in_stall is low; the column register is read and written in the
// same cycle, so the clock period is bounded by that single loop through
// the stop comparators.
// Reset clears the column, the configuration and both valid flags.
// When the receiver stalls, the result register holds and the input
// register fills; in_stall is raised only when both are occupied.
module tab_stop_expander_unit #(
	parameter int MAX_STOPS = tse_pkg::DEF_MAX_STOPS,
	parameter int TAB_WIDTH = tse_pkg::DEF_TAB_WIDTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [tse_pkg::CHAR_W-1:0]        in_char,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [tse_pkg::CHAR_W-1:0]        out_char,
	output logic [tse_pkg::COUNT_W-1:0]       repeat_count,
	output logic [tse_pkg::COLUMN_W-1:0]      column_after,
	input  logic                              cfg_write,
	input  logic [tse_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [tse_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import tse_pkg::*;

	logic [MAX_STOPS-1:0][STOP_W-1:0] stops;
	logic [USED_W-1:0]                stops_used;

	logic                valid_s1;
	logic [CHAR_W-1:0]   char_s1;
	logic                valid_s2;
	logic [CHAR_W-1:0]   char_s2;
	logic [COUNT_W-1:0]  count_s2;
	logic [COLUMN_W-1:0] column_s2;
	logic [COLUMN_W-1:0] column_q;

	logic                advance;
	logic                in_take;
	logic [COUNT_W-1:0]  tab_dist;
	logic [CHAR_W-1:0]   char_next;
	logic [COUNT_W-1:0]  count_next;
	logic [COLUMN_W:0]   column_sum;
	logic [COLUMN_W-1:0] column_next;

	tse_cfg_regs #(
		.MAX_STOPS (MAX_STOPS)
	) u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.stops      (stops),
		.stops_used (stops_used)
	);

	tse_tab_dist #(
		.MAX_STOPS (MAX_STOPS),
		.TAB_WIDTH (TAB_WIDTH)
	) u_dist (
		.column     (column_q),
		.stops      (stops),
		.stops_used (stops_used),
		.distance   (tab_dist)
	);

	// Handshake: the held request moves on whenever the result register is
	// free or being emptied; a new request is taken then or while none is held.
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && valid_s2 && out_stall;
	assign in_take  = in_valid && !in_stall;

	// Result of the held request against the current column.
	always_comb begin
		char_next  = char_s1;
		count_next = COUNT_W'(1);
		column_sum = {1'b0, column_q} + (COLUMN_W + 1)'(1);
		if (char_s1 == CHAR_TAB) begin
			char_next  = CHAR_SPACE;
			count_next = tab_dist;
			column_sum = {1'b0, column_q} + (COLUMN_W + 1)'(tab_dist);
		end else if (char_s1 == CHAR_NEWLINE) begin
			column_sum = '0;
		end
	end

	// The column saturates at its top value.
	assign column_next = column_sum[COLUMN_W] ? COLUMN_MAX : column_sum[COLUMN_W-1:0];

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			char_s1 <= in_char;
		end
	end

	// Result register and column tracker.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			column_q <= '0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
			column_q <= column_next;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			char_s2   <= char_next;
			count_s2  <= count_next;
			column_s2 <= column_next;
		end
	end

	assign out_valid    = valid_s2;
	assign out_char     = char_s2;
	assign repeat_count = count_s2;
	assign column_after = column_s2;

	// The tracked column always matches the last result produced.
	a_column_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (column_s2 == column_q))
		else $error("column register differs from last result");

	// A newline result restarts the line with a single copy.
	a_newline: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && (char_s2 == CHAR_NEWLINE)) |->
			((column_s2 == '0) && (count_s2 == COUNT_W'(1))))
		else $error("newline result with wrong count or column");

	// Every result carries at least one copy.
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (count_s2 != '0))
		else $error("zero repeat count");

	// The input side stalls only when both registers are full and blocked.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("input stalled without a full pipeline");

endmodule

// File: bench/tab_stop_expander_unit_tb.sv
`timescale 1ns / 1ps

module tab_stop_expander_unit_tb;

	import tse_pkg::*;

	localparam int MAX_STOPS_TB = DEF_MAX_STOPS;
	localparam int TAB_WIDTH_TB = DEF_TAB_WIDTH;

	// One result as it leaves the block.
	typedef struct packed {
		logic [CHAR_W-1:0]   ch;
		logic [COUNT_W-1:0]  count;
		logic [COLUMN_W-1:0] col;
	} expansion_t;

	typedef enum logic {ROW_CHAR, ROW_REG} row_kind_t;

	// One line of the directed plan: a character request or a register write.
	typedef struct {
		row_kind_t           kind;
		cfg_reg_t            idx;
		logic [CFG_DATA_W-1:0] data;
		logic [CHAR_W-1:0]   ch;
		bit                  typed;
		expansion_t          want;
	} plan_row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_stall;
	logic [CHAR_W-1:0]      in_char;
	logic                   out_valid;
	logic                   out_stall;
	logic [CHAR_W-1:0]      out_char;
	logic [COUNT_W-1:0]     repeat_count;
	logic [COLUMN_W-1:0]    column_after;
	logic                   cfg_write;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	// Predictor copy of the block's state and registers.
	logic [COLUMN_W-1:0]   col_now;
	logic [CFG_DATA_W-1:0] stop_word;
	logic [USED_W-1:0]     stops_used;

	expansion_t awaited_results[$];
	expansion_t drv_want;
	bit         drv_typed;
	expansion_t got_result;
	expansion_t head_result;

	int send_gap_pct;
	int recv_stall_pct;
	int accepted_n;
	int results_n;
	int fail_count;
	int tabs_n;
	int newlines_n;
	int saturated_n;
	int reg_sets_n;

	plan_row_t plan[$];

	tab_stop_expander_unit #(
		.MAX_STOPS(MAX_STOPS_TB),
		.TAB_WIDTH(TAB_WIDTH_TB)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_char(in_char),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_char(out_char),
		.repeat_count(repeat_count),
		.column_after(column_after),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Distance to the first valid stop beyond the column, else to the next
	// multiple of the tab width; the column saturates at its maximum.
	function automatic expansion_t expand_char(input logic [CHAR_W-1:0] c,
			input logic [COLUMN_W-1:0] col);
		expansion_t r;
		int used;
		int span;
		int next;
		used = (int'(stops_used) > MAX_STOPS_TB) ? MAX_STOPS_TB : int'(stops_used);
		if (c == CHAR_TAB) begin
			span = TAB_WIDTH_TB - (int'(col) % TAB_WIDTH_TB);
			for (int k = used - 1; k >= 0; k--) begin
				if (stop_word[8*k +: 8] > col) begin
					span = int'(stop_word[8*k +: 8]) - int'(col);
				end
			end
			next = int'(col) + span;
			r.ch = CHAR_SPACE;
		end else if (c == CHAR_NEWLINE) begin
			span = 1;
			next = 0;
			r.ch = c;
		end else begin
			span = 1;
			next = int'(col) + 1;
			r.ch = c;
		end
		if (next > int'(COLUMN_MAX)) begin
			next = int'(COLUMN_MAX);
		end
		r.count = span[COUNT_W-1:0];
		r.col = next[COLUMN_W-1:0];
		return r;
	endfunction

	function automatic plan_row_t char_step(input logic [CHAR_W-1:0] c);
		plan_row_t r;
		r = '{ROW_CHAR, REG_STOP_COLUMNS, '0, c, 1'b0, '0};
		return r;
	endfunction

	function automatic plan_row_t typed_step(input logic [CHAR_W-1:0] c,
			input logic [CHAR_W-1:0] ch, input logic [COUNT_W-1:0] cnt,
			input logic [COLUMN_W-1:0] col);
		plan_row_t r;
		r = '{ROW_CHAR, REG_STOP_COLUMNS, '0, c, 1'b1, '{ch, cnt, col}};
		return r;
	endfunction

	function automatic plan_row_t reg_step(input cfg_reg_t idx,
			input logic [CFG_DATA_W-1:0] data);
		plan_row_t r;
		r = '{ROW_REG, idx, data, '0, 1'b0, '0};
		return r;
	endfunction

	task automatic note_fail(input string msg);
		if (fail_count < 10) begin
			$display("%s", msg);
		end
		fail_count++;
	endtask

	// Receiver stalls at random at the configured rate.
	always @(negedge clk) begin
		out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	// Predict on every accepted request and check every accepted result.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				head_result = expand_char(in_char, col_now);
				col_now = head_result.col;
				if (in_char == CHAR_TAB) begin
					tabs_n++;
				end
				if (in_char == CHAR_NEWLINE) begin
					newlines_n++;
				end
				if (head_result.col == COLUMN_MAX) begin
					saturated_n++;
				end
				awaited_results.push_back(drv_typed ? drv_want : head_result);
				accepted_n++;
			end
			if (out_valid && !out_stall) begin
				got_result = '{out_char, repeat_count, column_after};
				if (awaited_results.size() == 0) begin
					note_fail($sformatf("unexpected result: char %0d count %0d col %0d",
						out_char, repeat_count, column_after));
				end else begin
					head_result = awaited_results.pop_front();
					if (got_result.ch !== head_result.ch
							|| got_result.count !== head_result.count
							|| got_result.col !== head_result.col) begin
						note_fail($sformatf(
							"result %0d: expected char %0d count %0d col %0d, got %0d %0d %0d",
							results_n, head_result.ch, head_result.count, head_result.col,
							got_result.ch, got_result.count, got_result.col));
					end
				end
				results_n++;
			end
		end
	end

	// Offer one character and wait until the block has taken it.
	task automatic send_char(input logic [CHAR_W-1:0] c, input bit typed,
			input expansion_t want);
		int seen;
		while ($urandom_range(0, 99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		seen = accepted_n;
		in_valid <= 1'b1;
		in_char <= c;
		drv_typed <= typed;
		drv_want <= want;
		do begin
			@(negedge clk);
		end while (accepted_n == seen);
	endtask

	// Stop sending and let every awaited result arrive.
	task automatic settle(input int max_cycles);
		int waited;
		waited = 0;
		in_valid <= 1'b0;
		while (awaited_results.size() != 0 && waited < max_cycles) begin
			@(negedge clk);
			waited++;
		end
		repeat (4) @(negedge clk);
		if (awaited_results.size() != 0) begin
			note_fail($sformatf("%0d results never arrived", awaited_results.size()));
			awaited_results.delete();
		end
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_write <= 1'b0;
		if (idx == REG_STOP_COLUMNS) begin
			stop_word = data;
		end else begin
			stops_used = data[USED_W-1:0];
		end
	endtask

	// Run limit, far beyond the slowest correct run.
	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		int mode;
		int nl_pct;
		int roll;
		int s;
		logic [CFG_DATA_W-1:0] word;
		logic [CHAR_W-1:0] c;

		arst_n = 1'b0;
		in_valid = 1'b0;
		in_char = '0;
		out_stall = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		drv_typed = 1'b0;
		drv_want = '0;
		col_now = '0;
		stop_word = '0;
		stops_used = '0;
		send_gap_pct = 25;
		recv_stall_pct = 75;
		accepted_n = 0;
		results_n = 0;
		fail_count = 0;
		tabs_n = 0;
		newlines_n = 0;
		saturated_n = 0;
		reg_sets_n = 0;

		// Directed plan: reset defaults, byte extremes, the widest tab,
		// saturation, too many stops, and stops out of order.
		plan.push_back(typed_step(CHAR_TAB, CHAR_SPACE, 8'd8, 8'd8));
		plan.push_back(typed_step(8'd65, 8'd65, 8'd1, 8'd9));
		plan.push_back(typed_step(CHAR_NEWLINE, CHAR_NEWLINE, 8'd1, 8'd0));
		plan.push_back(typed_step(8'h00, 8'h00, 8'd1, 8'd1));
		plan.push_back(typed_step(8'hFF, 8'hFF, 8'd1, 8'd2));
		plan.push_back(typed_step(CHAR_TAB, CHAR_SPACE, 8'd6, 8'd8));
		plan.push_back(typed_step(CHAR_NEWLINE, CHAR_NEWLINE, 8'd1, 8'd0));
		plan.push_back(reg_step(REG_STOP_COLUMNS, {CFG_DATA_W{1'b1}}));
		plan.push_back(reg_step(REG_STOPS_IN_USE, 64'd8));
		plan.push_back(typed_step(CHAR_TAB, CHAR_SPACE, 8'd255, 8'd255));
		plan.push_back(typed_step(CHAR_TAB, CHAR_SPACE, 8'd1, 8'd255));
		plan.push_back(typed_step(8'd122, 8'd122, 8'd1, 8'd255));
		plan.push_back(typed_step(CHAR_NEWLINE, CHAR_NEWLINE, 8'd1, 8'd0));
		plan.push_back(reg_step(REG_STOP_COLUMNS, 64'hC8643C28_140C0603));
		plan.push_back(reg_step(REG_STOPS_IN_USE, 64'd15));
		plan.push_back(char_step(CHAR_TAB));
		plan.push_back(char_step(CHAR_TAB));
		plan.push_back(char_step(8'd113));
		for (int k = 0; k < 7; k++) begin
			plan.push_back(char_step(CHAR_TAB));
		end
		plan.push_back(reg_step(REG_STOP_COLUMNS, 64'h050A3002_28081004));
		plan.push_back(reg_step(REG_STOPS_IN_USE, 64'hA5A5A5A5_5A5A5A53));
		plan.push_back(char_step(CHAR_NEWLINE));
		plan.push_back(char_step(CHAR_TAB));
		plan.push_back(char_step(CHAR_TAB));
		plan.push_back(char_step(CHAR_TAB));

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_REG) begin
				settle(5000);
				write_reg(plan[i].idx, plan[i].data);
				reg_sets_n++;
			end else begin
				send_char(plan[i].ch, plan[i].typed, plan[i].want);
			end
		end

		// Random part: three idling patterns, each over four register settings.
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_gap_pct = 25;
					recv_stall_pct = 75;
				end
				1: begin
					send_gap_pct = 75;
					recv_stall_pct = 25;
				end
				default: begin
					send_gap_pct = 0;
					recv_stall_pct = 0;
				end
			endcase
			for (int part = 0; part < 4; part++) begin
				settle(5000);
				mode = $urandom_range(0, 5);
				if (mode == 0) begin
					word = '0;
				end else if (mode == 1) begin
					word = {CFG_DATA_W{1'b1}};
				end else if (mode == 5) begin
					word = {$urandom, $urandom};
				end else begin
					// Ascending stops, the usual arrangement.
					s = $urandom_range(0, 40);
					for (int k = 0; k < MAX_STOPS_TB; k++) begin
						word[8*k +: 8] = s[7:0];
						s = s + $urandom_range(1, 40);
						if (s > 255) begin
							s = 255;
						end
					end
				end
				write_reg(REG_STOP_COLUMNS, word);
				roll = $urandom_range(0, 9);
				word = {$urandom, $urandom};
				word[USED_W-1:0] = (roll == 9) ? 4'($urandom_range(9, 15)) : 4'(roll);
				write_reg(REG_STOPS_IN_USE, word);
				reg_sets_n++;
				// Rare newlines in the first setting let lines run to saturation.
				nl_pct = (part == 0) ? 1 : $urandom_range(3, 12);
				repeat (133) begin
					roll = $urandom_range(0, 99);
					if (roll < 35) begin
						c = CHAR_TAB;
					end else if (roll < 35 + nl_pct) begin
						c = CHAR_NEWLINE;
					end else begin
						c = 8'($urandom_range(0, 255));
					end
					send_char(c, 1'b0, '0);
				end
			end
		end

		settle(5000);
		$display("Run covered %0d characters (%0d tabs, %0d newlines) over %0d stop settings.",
			accepted_n, tabs_n, newlines_n, reg_sets_n);
		$display("%0d results checked, %0d at the saturated column, %0d failures.",
			results_n, saturated_n, fail_count);
		if (fail_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// File: sim.f
rtl/tse_pkg.sv
rtl/tse_cfg_regs.sv
rtl/tse_tab_dist.sv
rtl/tab_stop_expander_unit.sv
bench/tab_stop_expander_unit_tb.sv
